[rtl/core/tcch_pkg.sv]
// Package for the tilt-compensated compass heading pipeline.
// Holds the CORDIC arctangent table and fixed constants; no dependencies.
`default_nettype none
package tcch_pkg;
  localparam int TableLen = 24;
  localparam logic signed [31:0] GainQ30 = 32'sh26DD3B6A;
  localparam logic [31:0] AtanTurn32 [TableLen] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };
endpackage
`default_nettype wire

[rtl/core/tilt_compensated_compass_heading.sv]
// Path: angle fold, roll/pitch CORDIC stages, stages A to C, half-plane fold, vectoring CORDIC stages, E, F.
// Throughput: one word per cycle unless stalled; each CORDIC iteration is its own stage.
// Stall freezes the whole pipeline; valid bits travel with the data.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
// Depends on tcch_pkg.
`default_nettype none
module tilt_compensated_compass_heading import tcch_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  signed [15:0] mag_x,
  input  wire  signed [15:0] mag_y,
  input  wire  signed [15:0] mag_z,
  input  wire  signed [15:0] roll_angle,
  input  wire  signed [15:0] pitch_angle,
  output logic               out_valid,
  input  wire                out_stall,
  output logic        [15:0] heading_centideg
);
  localparam int NS = (CORDIC_STEPS < TableLen) ? CORDIC_STEPS : TableLen;
  localparam int AB = ANGLE_BITS;
  localparam int ZW = AB + 2;
  localparam int VW = 52;
  localparam int NSTG = 2 * NS + 7;
  localparam logic signed [ZW-1:0] QTR = ZW'(1) <<< (AB - 2);
  localparam logic signed [ZW-1:0] HALF = ZW'(1) <<< (AB - 1);

  function automatic logic signed [ZW-1:0] atan_step(input int i);
    logic [32:0] t;
    t = {1'b0, AtanTurn32[i]} + (33'd1 << (31 - AB));
    return ZW'(signed'({1'b0, t >> (32 - AB)}));
  endfunction

  function automatic logic signed [ZW-1:0] to_int(input logic signed [15:0] a);
    logic signed [ZW+15:0] w;
    w = (ZW+16)'(a);
    if (AB >= 16) return ZW'(w <<< (AB - 16));
    else return ZW'(w >>> (16 - AB));
  endfunction

  function automatic logic signed [16:0] q15(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = (v + 34'sd16384) >>> 15;
    if (r > 34'sd32767) r = 34'sd32767;
    if (r < -34'sd32767) r = -34'sd32767;
    return r[16:0];
  endfunction

  logic adv;
  logic [NSTG-1:0] vld;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NSTG-2:0], in_valid};
  end

  logic signed [33:0] rx [NS+1], ry [NS+1], px [NS+1], py [NS+1];
  logic signed [ZW-1:0] rzs [NS+1], pzs [NS+1];
  logic rfs [NS+1], pfs [NS+1];
  logic signed [15:0] mxs [NS+1], mys [NS+1], mzs [NS+1];

  // stage 0: angle fold
  always_ff @(posedge clk) begin
    if (adv) begin
      logic signed [ZW-1:0] r, p;
      logic fr, fp;
      r = to_int(roll_angle);
      p = to_int(pitch_angle);
      fr = 1'b0;
      fp = 1'b0;
      if (r > QTR) begin
        r = r - HALF;
        fr = 1'b1;
      end else if (r < -QTR) begin
        r = r + HALF;
        fr = 1'b1;
      end
      if (p > QTR) begin
        p = p - HALF;
        fp = 1'b1;
      end else if (p < -QTR) begin
        p = p + HALF;
        fp = 1'b1;
      end
      rx[0] <= 34'(GainQ30); ry[0] <= '0; px[0] <= 34'(GainQ30); py[0] <= '0;
      rzs[0] <= r; pzs[0] <= p; rfs[0] <= fr; pfs[0] <= fp;
      mxs[0] <= mag_x; mys[0] <= mag_y; mzs[0] <= mag_z;
    end
  end

  // rotation stages
  for (genvar i = 0; i < NS; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (adv) begin
        if (rzs[i] >= 0) begin
          rx[i+1] <= rx[i] - (ry[i] >>> i); ry[i+1] <= ry[i] + (rx[i] >>> i);
          rzs[i+1] <= rzs[i] - atan_step(i);
        end else begin
          rx[i+1] <= rx[i] + (ry[i] >>> i); ry[i+1] <= ry[i] - (rx[i] >>> i);
          rzs[i+1] <= rzs[i] + atan_step(i);
        end
        if (pzs[i] >= 0) begin
          px[i+1] <= px[i] - (py[i] >>> i); py[i+1] <= py[i] + (px[i] >>> i);
          pzs[i+1] <= pzs[i] - atan_step(i);
        end else begin
          px[i+1] <= px[i] + (py[i] >>> i); py[i+1] <= py[i] - (px[i] >>> i);
          pzs[i+1] <= pzs[i] + atan_step(i);
        end
        rfs[i+1] <= rfs[i]; pfs[i+1] <= pfs[i];
        mxs[i+1] <= mxs[i]; mys[i+1] <= mys[i]; mzs[i+1] <= mzs[i];
      end
    end
  end

  // stage A: Q15 sin/cos
  logic signed [16:0] sr, cr, sp, cp;
  logic signed [15:0] mxa, mya, mza;
  always_ff @(posedge clk) begin
    if (adv) begin
      cr <= q15(rfs[NS] ? -rx[NS] : rx[NS]);
      sr <= q15(rfs[NS] ? -ry[NS] : ry[NS]);
      cp <= q15(pfs[NS] ? -px[NS] : px[NS]);
      sp <= q15(pfs[NS] ? -py[NS] : py[NS]);
      mxa <= mxs[NS]; mya <= mys[NS]; mza <= mzs[NS];
    end
  end

  // stage B: first products
  logic signed [32:0] pxc, pyc, pzs_b, srsp;
  logic signed [15:0] myb;
  always_ff @(posedge clk) begin
    if (adv) begin
      pxc <= 33'(mxa * cp);
      pyc <= 33'(mya * cr);
      pzs_b <= 33'(mza * sr);
      srsp <= 33'(sr * sp);
      myb <= mya;
    end
  end

  // stage C: xh, yh
  logic signed [VW-1:0] xh, yh;
  always_ff @(posedge clk) begin
    if (adv) begin
      xh <= (VW'(pxc) <<< 15) + VW'(myb * srsp);
      yh <= (VW'(pyc) + VW'(pzs_b)) <<< 15;
    end
  end

  // stage D: half-plane fold
  logic signed [VW-1:0] vx [NS+1], vy [NS+1];
  logic signed [ZW-1:0] vz [NS+1];
  logic vzero [NS+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      vzero[0] <= (xh == 0) && (yh == 0);
      if (xh < 0) begin
        vx[0] <= -xh; vy[0] <= -yh; vz[0] <= ZW'(1) <<< (AB - 1);
      end else begin
        vx[0] <= xh; vy[0] <= yh; vz[0] <= '0;
      end
    end
  end
  for (genvar i = 0; i < NS; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (adv) begin
        if (vy[i] >= 0) begin
          vx[i+1] <= vx[i] + (vy[i] >>> i); vy[i+1] <= vy[i] - (vx[i] >>> i);
          vz[i+1] <= vz[i] + atan_step(i);
        end else begin
          vx[i+1] <= vx[i] - (vy[i] >>> i); vy[i+1] <= vy[i] + (vx[i] >>> i);
          vz[i+1] <= vz[i] - atan_step(i);
        end
        vzero[i+1] <= vzero[i];
      end
    end
  end

  // stage E: scale to centidegrees
  logic [AB+16:0] hs;
  logic hz;
  always_ff @(posedge clk) begin
    if (adv) begin
      hs <= (AB+17)'(AB'(vz[NS]) * 17'd36000) + ((AB+17)'(1) << (AB - 1));
      hz <= vzero[NS];
    end
  end

  // stage F: output
  logic [16:0] hq;
  assign hq = 17'(hs >> AB);
  always_ff @(posedge clk) begin
    if (adv) heading_centideg <= (hz || hq >= 17'd36000) ? 16'd0 : hq[15:0];
  end

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> heading_centideg < 16'd36000) else $error("heading out of range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(heading_centideg))
    else $error("stalled result changed");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall) else $error("spurious input stall");
endmodule
`default_nettype wire
